FILE: src/disk_scan_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Disk scan scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISK_SCAN_SCHEDULER_TOP_DEFINES_SVH
`define DISK_SCAN_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define DSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dss assertion failed");

// next-cycle implication
`define DSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dss assertion failed");

`endif

FILE: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// Disk scan scheduler package
// Shared constants, register codes and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

	localparam int MAX_REQ     = 32;
	localparam int ADDR_W      = $clog2(MAX_REQ);
	localparam int CNT_W       = $clog2(MAX_REQ + 1);
	localparam int STEP_W      = $clog2(MAX_REQ + 2);
	localparam int TRACK_W     = 16;
	localparam int TOTAL_W     = 23;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_HEAD_INIT  = 2'd0;
	localparam logic [1:0] REG_MOVE_RIGHT = 2'd1;
	localparam logic [1:0] REG_LAST_TRACK = 2'd2;

	localparam logic [TRACK_W-1:0] HEAD_INIT_RST  = 16'd0;
	localparam logic               MOVE_RIGHT_RST = 1'b1;
	localparam logic [TRACK_W-1:0] LAST_TRACK_RST = 16'd199;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [TRACK_W-1:0] head_init;
		logic               move_right;
		logic [TRACK_W-1:0] last_track;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/dss_front.sv
// ----------------------------------------------------------------------------
// Disk scan scheduler front end
// Accepts request items, clamps the track to the disk size and registers them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dss_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [dss_pkg::TRACK_W-1:0]  s_track,
	input  wire                          s_last,
	input  wire  [dss_pkg::TRACK_W-1:0]  last_track,
	output logic                         q_valid,
	input  wire                          q_ready,
	output dss_pkg::req_t                q_req
);

	logic          valid_s1;
	dss_pkg::req_t req_s1;
	dss_pkg::req_t req_in;

	// clamp tracks beyond the disk end
	always_comb begin
		req_in.track = (s_track > last_track) ? last_track : s_track;
		req_in.last  = s_last;
	end

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_req    = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req_in;
		end
	end

endmodule

`default_nettype wire

FILE: src/dss_queue.sv
// ----------------------------------------------------------------------------
// Disk scan scheduler request queue
// Short FIFO between front end and scheduling engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dss_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  dss_pkg::req_t  in_req,
	output logic           out_valid,
	input  wire            out_pop,
	output dss_pkg::req_t  out_req
);

	dss_pkg::req_t                 slot_q [dss_pkg::QUEUE_DEPTH];
	logic [dss_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dss_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dss_pkg::QCNT_W-1:0]    fill_q;
	logic                          push;
	logic                          pop;

	assign in_ready  = (fill_q != dss_pkg::QCNT_W'(dss_pkg::QUEUE_DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_req   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dss_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dss_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + dss_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - dss_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_req;
		end
	end

endmodule

`default_nettype wire

FILE: src/dss_back.sv
// ----------------------------------------------------------------------------
// Disk scan scheduler engine
// Sorted insertion into the request store, split search and SCAN emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disk_scan_scheduler_top_defines.svh"

module dss_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  dss_pkg::cfg_t                 cfg,
	input  wire                           q_valid,
	output logic                          q_pop,
	input  dss_pkg::req_t                 q_req,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [dss_pkg::TRACK_W-1:0]   served_track,
	output logic [dss_pkg::TRACK_W-1:0]   seek_distance,
	output logic [dss_pkg::TOTAL_W-1:0]   total_seek,
	output logic                          edge_visit,
	output logic                          overflow,
	output logic                          final_step
);

	localparam int ADDR_W  = dss_pkg::ADDR_W;
	localparam int CNT_W   = dss_pkg::CNT_W;
	localparam int STEP_W  = dss_pkg::STEP_W;
	localparam int TRACK_W = dss_pkg::TRACK_W;
	localparam int TOTAL_W = dss_pkg::TOTAL_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS     = 4'd1;
	localparam logic [3:0] S_PUT     = 4'd2;
	localparam logic [3:0] S_SPL_RD  = 4'd3;
	localparam logic [3:0] S_SPL_CMP = 4'd4;
	localparam logic [3:0] S_PLAN    = 4'd5;
	localparam logic [3:0] S_EM_RD   = 4'd6;
	localparam logic [3:0] S_EM_WR   = 4'd7;

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic                dropped_q;
	logic [TRACK_W-1:0]  trk_q;
	logic                fin_q;
	logic [CNT_W-1:0]    p_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    split_q;
	logic [CNT_W-1:0]    first_left_q;
	logic [CNT_W-1:0]    second_q;
	logic                turned_q;
	logic                asc_q;
	logic                dir_q;
	logic                edge_q;
	logic [STEP_W-1:0]   steps_left_q;
	logic [TRACK_W-1:0]  pos_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                ovf_q;

	logic [TRACK_W-1:0]  mem [dss_pkg::MAX_REQ];
	logic [TRACK_W-1:0]  rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	logic [TRACK_W-1:0]  mem_wd;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_ra;

	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    p_m2;
	logic                store_ok;
	logic                take_edge;
	logic                out_load;
	logic [TRACK_W-1:0]  cur_track;
	logic [TRACK_W-1:0]  seek_gap;
	logic [3:0]          after_ins;

	assign cnt_m1    = count_q - CNT_W'(1);
	assign p_m2      = p_q - CNT_W'(2);
	assign store_ok  = count_q < CNT_W'(dss_pkg::MAX_REQ);
	assign take_edge = (first_left_q == '0) && (second_q != '0) && !turned_q;
	assign after_ins = fin_q ? S_SPL_RD : S_IDLE;

	// next visited track and its distance from the head
	always_comb begin
		if (edge_q) begin
			cur_track = dir_q ? cfg.last_track : '0;
		end else begin
			cur_track = rdata_q;
		end
		seek_gap = (cur_track >= pos_q) ? (cur_track - pos_q) : (pos_q - cur_track);
	end

	// memory port and handshake control
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = p_q[ADDR_W-1:0];
		mem_wd   = trk_q;
		mem_re   = 1'b0;
		mem_ra   = idx_q[ADDR_W-1:0];
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (store_ok) begin
						if (count_q == '0) begin
							mem_we = 1'b1;
							mem_wa = '0;
							mem_wd = q_req.track;
						end else begin
							mem_re = 1'b1;
							mem_ra = cnt_m1[ADDR_W-1:0];
						end
					end
				end
			end
			S_INS: begin
				mem_we = 1'b1;
				if (rdata_q > trk_q) begin
					mem_wd = rdata_q;
					if (p_q > CNT_W'(1)) begin
						mem_re = 1'b1;
						mem_ra = p_m2[ADDR_W-1:0];
					end
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
			end
			S_SPL_RD: begin
				mem_re = (idx_q != count_q);
			end
			S_EM_RD: begin
				mem_re = !take_edge;
			end
			S_EM_WR: begin
				out_load = !m_tvalid || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			fin_q        <= 1'b0;
			p_q          <= '0;
			idx_q        <= '0;
			split_q      <= '0;
			first_left_q <= '0;
			second_q     <= '0;
			turned_q     <= 1'b0;
			asc_q        <= 1'b0;
			dir_q        <= 1'b0;
			edge_q       <= 1'b0;
			steps_left_q <= '0;
			ovf_q        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						trk_q <= q_req.track;
						fin_q <= q_req.last;
						idx_q <= '0;
						if (!store_ok) begin
							dropped_q <= 1'b1;
							state_q   <= q_req.last ? S_SPL_RD : S_IDLE;
						end else if (count_q == '0) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= q_req.last ? S_SPL_RD : S_IDLE;
						end else begin
							p_q     <= count_q;
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					// shift larger entries up one slot until the place is found
					if (rdata_q > trk_q) begin
						p_q <= p_q - CNT_W'(1);
						if (p_q <= CNT_W'(1)) begin
							state_q <= S_PUT;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= after_ins;
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= after_ins;
				end
				S_SPL_RD: begin
					if (idx_q == count_q) begin
						split_q <= count_q;
						state_q <= S_PLAN;
					end else begin
						state_q <= S_SPL_CMP;
					end
				end
				S_SPL_CMP: begin
					if (rdata_q >= cfg.head_init) begin
						split_q <= idx_q;
						state_q <= S_PLAN;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SPL_RD;
					end
				end
				S_PLAN: begin
					dir_q    <= cfg.move_right;
					turned_q <= 1'b0;
					ovf_q    <= dropped_q;
					pos_q    <= cfg.head_init;
					total_q  <= '0;
					if (cfg.move_right) begin
						first_left_q <= count_q - split_q;
						second_q     <= split_q;
						idx_q        <= split_q;
						asc_q        <= 1'b1;
						steps_left_q <= STEP_W'(count_q) + STEP_W'(split_q != '0);
					end else begin
						first_left_q <= split_q;
						second_q     <= count_q - split_q;
						idx_q        <= split_q - CNT_W'(1);
						asc_q        <= 1'b0;
						steps_left_q <= STEP_W'(count_q) + STEP_W'(split_q != count_q);
					end
					count_q   <= '0;
					dropped_q <= 1'b0;
					state_q   <= S_EM_RD;
				end
				S_EM_RD: begin
					if (take_edge) begin
						// turn at the disk edge, then sweep the other way
						edge_q   <= 1'b1;
						turned_q <= 1'b1;
						asc_q    <= !dir_q;
						idx_q    <= dir_q ? (split_q - CNT_W'(1)) : split_q;
					end else begin
						edge_q <= 1'b0;
						idx_q  <= asc_q ? (idx_q + CNT_W'(1)) : (idx_q - CNT_W'(1));
						if (first_left_q != '0) begin
							first_left_q <= first_left_q - CNT_W'(1);
						end
					end
					state_q <= S_EM_WR;
				end
				S_EM_WR: begin
					if (out_load) begin
						steps_left_q <= steps_left_q - STEP_W'(1);
						pos_q        <= cur_track;
						total_q      <= total_q + TOTAL_W'(seek_gap);
						state_q      <= (steps_left_q == STEP_W'(1)) ? S_IDLE : S_EM_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			served_track  <= cur_track;
			seek_distance <= seek_gap;
			total_seek    <= total_q + TOTAL_W'(seek_gap);
			edge_visit    <= edge_q;
			overflow      <= ovf_q;
			final_step    <= (steps_left_q == STEP_W'(1));
		end
	end

	`DSS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(dss_pkg::MAX_REQ))
	`DSS_ASSERT_IMP(a_steps_live, state_q == S_EM_RD || state_q == S_EM_WR, steps_left_q != '0)
	`DSS_ASSERT_NXT(a_final_idle, out_load && steps_left_q == STEP_W'(1), state_q == S_IDLE && final_step)
	`DSS_ASSERT_NXT(a_batch_clear, state_q == S_PLAN, count_q == '0 && !dropped_q)

endmodule

`default_nettype wire

FILE: src/disk_scan_scheduler_top.sv
// Disk scan scheduler (SCAN / elevator order).
// Input stream s_*: one track request per item, tdata[15:0] the track (clamped to
// last_track), tlast marks the final request of a batch. Up to 32 requests are kept
// sorted; further requests of a batch are dropped and flagged on every result.
// Output stream m_*: one item per visited track, tlast on the final step.
// Registers over APB: initial head track (0x0), move_right (0x4), last_track (0x8).
// Flow: an item passes the front register and the queue; sorted insertion of a
// request then writes an empty store directly, else shifts every stored entry
// above it up one slot, one at a time, paced by the read and write ports of the
// single store memory. The final item then searches the split point entry by
// entry from the lowest and emits n or n+1 steps.
// Reset clears the batch, the queue and the output; registers take their
// defaults (head 0, moving right, last track 199); the store needs no clearing.
// A stalled receiver holds the output register; the engine waits, the queue
// fills and then s_tready drops.
// ----------------------------------------------------------------------------
// Disk scan scheduler top level
// APB register file, front end, request queue and scheduling engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disk_scan_scheduler_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// config port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [dss_pkg::PADDR_W-1:0]  paddr,
	input  wire  [dss_pkg::PDATA_W-1:0]  pwdata,
	output logic [dss_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// request stream
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [15:0]                  s_tdata,   // [15:0] request_track
	input  wire                          s_tlast,   // batch_end
	// schedule stream
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [55:0]                  m_tdata,   // [15:0] served_track,
	                                                // [31:16] seek_distance,
	                                                // [54:32] total_seek, [55] zero
	output logic [1:0]                   m_tuser,   // [0] edge_visit, [1] overflow
	output logic                         m_tlast    // final_step
);

	dss_pkg::cfg_t cfg_q;
	logic          cfg_wr;
	logic [1:0]    reg_idx;

	logic          fq_valid;
	logic          fq_ready;
	dss_pkg::req_t fq_req;
	logic          qb_valid;
	logic          qb_pop;
	dss_pkg::req_t qb_req;

	logic [dss_pkg::TRACK_W-1:0] served_track;
	logic [dss_pkg::TRACK_W-1:0] seek_distance;
	logic [dss_pkg::TOTAL_W-1:0] total_seek;
	logic                        edge_visit;
	logic                        overflow;
	logic                        final_step;

	// register file: write on the access phase, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_init  <= dss_pkg::HEAD_INIT_RST;
			cfg_q.move_right <= dss_pkg::MOVE_RIGHT_RST;
			cfg_q.last_track <= dss_pkg::LAST_TRACK_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				dss_pkg::REG_HEAD_INIT:  cfg_q.head_init  <= pwdata[15:0];
				dss_pkg::REG_MOVE_RIGHT: cfg_q.move_right <= pwdata[0];
				dss_pkg::REG_LAST_TRACK: cfg_q.last_track <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// read back; unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			dss_pkg::REG_HEAD_INIT:  prdata = {16'd0, cfg_q.head_init};
			dss_pkg::REG_MOVE_RIGHT: prdata = {31'd0, cfg_q.move_right};
			dss_pkg::REG_LAST_TRACK: prdata = {16'd0, cfg_q.last_track};
			default:                 prdata = '0;
		endcase
	end

	// clamp and register each request
	dss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_track    (s_tdata),
		.s_last     (s_tlast),
		.last_track (cfg_q.last_track),
		.q_valid    (fq_valid),
		.q_ready    (fq_ready),
		.q_req      (fq_req)
	);

	// decouple intake from the engine
	dss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_req    (fq_req),
		.out_valid (qb_valid),
		.out_pop   (qb_pop),
		.out_req   (qb_req)
	);

	// insert, search the split and emit the schedule
	dss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (qb_valid),
		.q_pop         (qb_pop),
		.q_req         (qb_req),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.served_track  (served_track),
		.seek_distance (seek_distance),
		.total_seek    (total_seek),
		.edge_visit    (edge_visit),
		.overflow      (overflow),
		.final_step    (final_step)
	);

	// pack the result item
	assign m_tdata = {1'b0, total_seek, seek_distance, served_track};
	assign m_tuser = {overflow, edge_visit};
	assign m_tlast = final_step;

endmodule

`default_nettype wire
